>>> design/sidfl_pkg.sv
// sidfl_pkg: command and status codes, sequencer states and register indexes
// for the sync id free list allocator; no dependencies
package sidfl_pkg;

  typedef enum logic [2:0] {
    CMD_INIT       = 3'd0,
    CMD_ALLOC_SYNC = 3'd1,
    CMD_ALLOC_GRP  = 3'd2,
    CMD_ALLOC_MON  = 3'd3,
    CMD_REL_SYNC   = 3'd4,
    CMD_REL_MON    = 3'd5,
    CMD_DUMMY      = 3'd6,
    CMD_NOP        = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NONE     = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_RESERVED = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INIT_SYNC,
    S_INIT_MON,
    S_GRP_RD,
    S_GRP_WAIT,
    S_SPLIT,
    S_SGL_RD,
    S_SGL_WAIT,
    S_MON_RD,
    S_MON_WAIT,
    S_GRPA_RD,
    S_GRPA_WAIT,
    S_DONE
  } state_e;

  localparam logic [2:0] REG_SYNC_BASE = 3'd0;
  localparam logic [2:0] REG_SYNC_CNT  = 3'd1;
  localparam logic [2:0] REG_SYNC_RLO  = 3'd2;
  localparam logic [2:0] REG_SYNC_RHI  = 3'd3;
  localparam logic [2:0] REG_MON_BASE  = 3'd4;
  localparam logic [2:0] REG_MON_CNT   = 3'd5;
  localparam logic [2:0] REG_MON_RLO   = 3'd6;
  localparam logic [2:0] REG_MON_RHI   = 3'd7;

  typedef struct packed {
    logic [11:0] sync_base;
    logic [9:0]  sync_count;
    logic [11:0] sync_rlo;
    logic [11:0] sync_rhi;
    logic [11:0] mon_base;
    logic [8:0]  mon_count;
    logic [11:0] mon_rlo;
    logic [11:0] mon_rhi;
  } cfg_t;

endpackage

>>> design/sidfl_ram.sv
// sidfl_ram: generic single write, single read ram with registered read data
// no dependencies
module sidfl_ram #(
  parameter int Width = 12,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> design/sidfl_regs.sv
// sidfl_regs: apb configuration registers of the allocator
// depends on sidfl_pkg
module sidfl_regs
  import sidfl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);
  cfg_t cfg_q;
  logic [2:0] idx;
  logic wr;

  assign idx = paddr[4:2];
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_SYNC_BASE: cfg_q.sync_base  <= pwdata[11:0];
        REG_SYNC_CNT:  cfg_q.sync_count <= pwdata[9:0];
        REG_SYNC_RLO:  cfg_q.sync_rlo   <= pwdata[11:0];
        REG_SYNC_RHI:  cfg_q.sync_rhi   <= pwdata[11:0];
        REG_MON_BASE:  cfg_q.mon_base   <= pwdata[11:0];
        REG_MON_CNT:   cfg_q.mon_count  <= pwdata[8:0];
        REG_MON_RLO:   cfg_q.mon_rlo    <= pwdata[11:0];
        REG_MON_RHI:   cfg_q.mon_rhi    <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SYNC_BASE: prdata = {20'd0, cfg_q.sync_base};
      REG_SYNC_CNT:  prdata = {22'd0, cfg_q.sync_count};
      REG_SYNC_RLO:  prdata = {20'd0, cfg_q.sync_rlo};
      REG_SYNC_RHI:  prdata = {20'd0, cfg_q.sync_rhi};
      REG_MON_BASE:  prdata = {20'd0, cfg_q.mon_base};
      REG_MON_CNT:   prdata = {23'd0, cfg_q.mon_count};
      REG_MON_RLO:   prdata = {20'd0, cfg_q.mon_rlo};
      REG_MON_RHI:   prdata = {20'd0, cfg_q.mon_rhi};
      default:       prdata = '0;
    endcase
  end
endmodule

>>> design/sync_id_free_list_allocator.sv
// Sync id free list allocator: three fifo free lists (single sync ids, sync
// groups, monitor ids) kept in rams and run by one sequencer with a shared id
// counter and range compare. A command is accepted when start_i is high and
// busy_o is low; its one result appears on the result ports for one cycle with
// done_o high, and the receiver cannot hold it off. A release is settled in
// dispatch; an allocation reads a list head and waits for the ram data, and
// one that splits a group first pushes each group member to the single list;
// a cached dummy or a request that finds nothing free goes straight to done.
// Init walks the managed sync ids, a group that touches the reserved window
// twice, then the monitor ids (counts clamped). No clearing pass after reset.
// depends on sidfl_pkg, sidfl_ram, sidfl_regs
module sync_id_free_list_allocator
  import sidfl_pkg::*;
#(
  parameter int SYNC_CAPACITY = 512,
  parameter int MON_CAPACITY  = 256,
  parameter int GROUP_SIZE    = 4,
  parameter int ID_BITS       = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  command_i,
  input  logic [11:0] release_id_i,
  output logic        done_o,
  output logic [11:0] id_out_o,
  output logic [1:0]  status_o,
  output logic        all_sync_free_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int GDEPTH = SYNC_CAPACITY / GROUP_SIZE + 1;
  localparam int SAW = $clog2(SYNC_CAPACITY);
  localparam int GAW = $clog2(GDEPTH);
  localparam int MAW = $clog2(MON_CAPACITY);
  localparam int SFW = $clog2(SYNC_CAPACITY + 1);
  localparam int GFW = $clog2(GDEPTH + 1);
  localparam int MFW = $clog2(MON_CAPACITY + 1);
  localparam int GSW = $clog2(GROUP_SIZE + 1);
  localparam int CW = 14;
  localparam logic [ID_BITS-1:0] GS_ID = ID_BITS'(GROUP_SIZE);

  cfg_t cfg;
  sidfl_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .pready, .cfg_o(cfg)
  );

  state_e state_q, state_d;
  cmd_e cmd_q;
  logic [ID_BITS-1:0] rid_q;
  logic [SAW-1:0] s_head_q;
  logic [SFW-1:0] s_fill_q;
  logic [GAW-1:0] g_head_q;
  logic [GFW-1:0] g_fill_q;
  logic [MAW-1:0] m_head_q;
  logic [MFW-1:0] m_fill_q;
  logic dummy_valid_q;
  logic [ID_BITS-1:0] dummy_id_q;
  logic [CW-1:0] k_q;
  logic [GSW-1:0] j_q;
  logic grp_any_q;
  logic [ID_BITS-1:0] grp_first_q;
  logic [11:0] id_q;
  logic [1:0] st_q;
  logic [ID_BITS-1:0] gval_q;
  // init emits group members only once the group is classified: a group that
  // holds a reserved id is re-walked member by member in a second pass
  logic init_rewalk_q;

  // effective counts
  logic [CW-1:0] sc_clamp, eff_sync, eff_mon;
  always_comb begin
    sc_clamp = (CW'(cfg.sync_count) > CW'(SYNC_CAPACITY)) ? CW'(SYNC_CAPACITY)
                                                         : CW'(cfg.sync_count);
    eff_sync = sc_clamp - (sc_clamp % CW'(GROUP_SIZE));
    eff_mon = (CW'(cfg.mon_count) > CW'(MON_CAPACITY)) ? CW'(MON_CAPACITY)
                                                      : CW'(cfg.mon_count);
  end

  // shared id counter and range compare
  logic [ID_BITS-1:0] cur_id;
  logic cur_sres, cur_mres, rid_sres, rid_mres;
  logic [ID_BITS-1:0] mbase_ext, sbase_ext;
  assign sbase_ext = ID_BITS'(cfg.sync_base);
  assign mbase_ext = ID_BITS'(cfg.mon_base);
  assign cur_id = (state_q == S_INIT_MON) ? mbase_ext + ID_BITS'(k_q)
                                          : sbase_ext + ID_BITS'(k_q)
                                            + ID_BITS'(j_q);
  assign cur_sres = (CW'(cur_id) >= CW'(cfg.sync_rlo)) && (CW'(cur_id) < CW'(cfg.sync_rhi));
  assign cur_mres = (CW'(cur_id) >= CW'(cfg.mon_rlo)) && (CW'(cur_id) < CW'(cfg.mon_rhi));
  assign rid_sres = (CW'(rid_q) >= CW'(cfg.sync_rlo)) && (CW'(rid_q) < CW'(cfg.sync_rhi));
  assign rid_mres = (CW'(rid_q) >= CW'(cfg.mon_rlo)) && (CW'(rid_q) < CW'(cfg.mon_rhi));

  // rams
  logic s_we, g_we, m_we;
  logic [ID_BITS-1:0] s_wd, g_wd, m_wd, s_rd, g_rd, m_rd;
  logic [SAW-1:0] s_wa;
  logic [GAW-1:0] g_wa;
  logic [MAW-1:0] m_wa;

  always_comb begin
    logic [SFW:0] ts;
    logic [GFW:0] tg;
    logic [MFW:0] tm;
    ts = (SFW+1)'(s_head_q) + (SFW+1)'(s_fill_q);
    if (ts >= (SFW+1)'(SYNC_CAPACITY)) ts = ts - (SFW+1)'(SYNC_CAPACITY);
    tg = (GFW+1)'(g_head_q) + (GFW+1)'(g_fill_q);
    if (tg >= (GFW+1)'(GDEPTH)) tg = tg - (GFW+1)'(GDEPTH);
    tm = (MFW+1)'(m_head_q) + (MFW+1)'(m_fill_q);
    if (tm >= (MFW+1)'(MON_CAPACITY)) tm = tm - (MFW+1)'(MON_CAPACITY);
    s_wa = SAW'(ts);
    g_wa = GAW'(tg);
    m_wa = MAW'(tm);
  end

  sidfl_ram #(.Width(ID_BITS), .Depth(SYNC_CAPACITY)) u_sgl (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_head_q),
    .rdata_o(s_rd));
  sidfl_ram #(.Width(ID_BITS), .Depth(GDEPTH)) u_grp (
    .clk_i, .we_i(g_we), .waddr_i(g_wa), .wdata_i(g_wd), .raddr_i(g_head_q),
    .rdata_o(g_rd));
  sidfl_ram #(.Width(ID_BITS), .Depth(MON_CAPACITY)) u_mon (
    .clk_i, .we_i(m_we), .waddr_i(m_wa), .wdata_i(m_wd), .raddr_i(m_head_q),
    .rdata_o(m_rd));

  logic s_full, g_full, m_full, last_j;
  assign s_full = s_fill_q >= SFW'(SYNC_CAPACITY);
  assign g_full = g_fill_q >= GFW'(GDEPTH);
  assign m_full = m_fill_q >= MFW'(MON_CAPACITY);
  assign last_j = j_q == GSW'(GROUP_SIZE - 1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start_i) state_d = S_DISPATCH;
      S_DISPATCH: begin
        unique case (cmd_q)
          CMD_INIT:       state_d = S_INIT_SYNC;
          CMD_ALLOC_SYNC: state_d = (s_fill_q != '0) ? S_SGL_RD
                                   : (g_fill_q != '0) ? S_GRP_RD : S_DONE;
          CMD_ALLOC_GRP:  state_d = (g_fill_q != '0) ? S_GRPA_RD : S_DONE;
          CMD_ALLOC_MON:  state_d = (m_fill_q != '0) ? S_MON_RD : S_DONE;
          CMD_DUMMY:      state_d = dummy_valid_q ? S_DONE
                                   : (s_fill_q != '0) ? S_SGL_RD
                                   : (g_fill_q != '0) ? S_GRP_RD : S_DONE;
          default:        state_d = S_DONE;
        endcase
      end
      S_INIT_SYNC: if (k_q >= eff_sync ||
                       (last_j && (init_rewalk_q || !(grp_any_q || cur_sres)) &&
                        k_q + CW'(GROUP_SIZE) >= eff_sync))
                     state_d = S_INIT_MON;
      S_INIT_MON:  if (k_q + 1'b1 >= eff_mon) state_d = S_DONE;
      S_GRP_RD:    state_d = S_GRP_WAIT;
      S_GRP_WAIT:  state_d = S_SPLIT;
      S_SPLIT:     if (last_j) state_d = S_SGL_RD;
      S_SGL_RD:    state_d = S_SGL_WAIT;
      S_SGL_WAIT:  state_d = S_DONE;
      S_MON_RD:    state_d = S_MON_WAIT;
      S_MON_WAIT:  state_d = S_DONE;
      S_GRPA_RD:   state_d = S_GRPA_WAIT;
      S_GRPA_WAIT: state_d = S_DONE;
      S_DONE:      state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // datapath outputs
  always_comb begin
    s_we = 1'b0; g_we = 1'b0; m_we = 1'b0;
    s_wd = cur_id; g_wd = grp_first_q / GS_ID; m_wd = cur_id;
    unique case (state_q)
      S_INIT_SYNC: if (k_q < eff_sync) begin
        if (init_rewalk_q) begin
          s_we = !cur_sres && !s_full;
        end else if (last_j && !grp_any_q && !cur_sres) begin
          g_we = !g_full;
          g_wd = grp_first_q / GS_ID;
        end
      end
      S_INIT_MON: m_we = (k_q < eff_mon) && !cur_mres && !m_full;
      S_SPLIT: begin
        s_we = !s_full;
        s_wd = gval_q * GS_ID + ID_BITS'(j_q);
      end
      S_DISPATCH: begin
        if (cmd_q == CMD_REL_SYNC && !rid_sres && CW'(s_fill_q) < eff_sync) begin
          s_we = 1'b1; s_wd = rid_q;
        end
        if (cmd_q == CMD_REL_MON && !rid_mres && CW'(m_fill_q) < eff_mon) begin
          m_we = 1'b1; m_wd = rid_q;
        end
      end
      default: ;
    endcase
  end

  logic [GAW-1:0] g_head_inc;
  logic [SAW-1:0] s_head_inc;
  logic [MAW-1:0] m_head_inc;
  assign g_head_inc = (32'(g_head_q) == GDEPTH - 1) ? '0 : g_head_q + 1'b1;
  assign s_head_inc = (32'(s_head_q) == SYNC_CAPACITY - 1) ? '0 : s_head_q + 1'b1;
  assign m_head_inc = (32'(m_head_q) == MON_CAPACITY - 1) ? '0 : m_head_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      s_head_q <= '0; s_fill_q <= '0;
      g_head_q <= '0; g_fill_q <= '0;
      m_head_q <= '0; m_fill_q <= '0;
      dummy_valid_q <= 1'b0; dummy_id_q <= '0;
      k_q <= '0; j_q <= '0; grp_any_q <= 1'b0; init_rewalk_q <= 1'b0;
      cmd_q <= CMD_NOP; rid_q <= '0; grp_first_q <= '0; gval_q <= '0;
      id_q <= '0; st_q <= ST_OK;
    end else begin
      state_q <= state_d;
      if (s_we) s_fill_q <= s_fill_q + 1'b1;
      if (g_we) g_fill_q <= g_fill_q + 1'b1;
      if (m_we) m_fill_q <= m_fill_q + 1'b1;
      unique case (state_q)
        S_IDLE: if (start_i) begin
          cmd_q <= cmd_e'(command_i);
          rid_q <= ID_BITS'(release_id_i);
          id_q <= '0; st_q <= ST_OK;
        end
        S_DISPATCH: begin
          k_q <= '0; j_q <= '0; grp_any_q <= 1'b0; init_rewalk_q <= 1'b0;
          grp_first_q <= sbase_ext;
          unique case (cmd_q)
            CMD_INIT: begin
              s_head_q <= '0; s_fill_q <= '0; g_head_q <= '0; g_fill_q <= '0;
              m_head_q <= '0; m_fill_q <= '0;
              dummy_valid_q <= 1'b0; dummy_id_q <= '0;
            end
            CMD_ALLOC_SYNC, CMD_ALLOC_GRP, CMD_ALLOC_MON:
              if ((cmd_q == CMD_ALLOC_SYNC && s_fill_q == '0 && g_fill_q == '0) ||
                  (cmd_q == CMD_ALLOC_GRP && g_fill_q == '0) ||
                  (cmd_q == CMD_ALLOC_MON && m_fill_q == '0)) st_q <= ST_NONE;
            CMD_DUMMY:
              if (dummy_valid_q) id_q <= 12'(dummy_id_q);
              else if (s_fill_q == '0 && g_fill_q == '0) st_q <= ST_NONE;
            CMD_REL_SYNC:
              if (rid_sres) st_q <= ST_RESERVED;
              else if (CW'(s_fill_q) >= eff_sync) st_q <= ST_OVERFLOW;
            CMD_REL_MON:
              if (rid_mres) st_q <= ST_RESERVED;
              else if (CW'(m_fill_q) >= eff_mon) st_q <= ST_OVERFLOW;
            default: ;
          endcase
        end
        S_INIT_SYNC: begin
          if (k_q < eff_sync) begin
            if (!init_rewalk_q) begin
              if (cur_sres) grp_any_q <= 1'b1;
              if (last_j) begin
                j_q <= '0;
                if (grp_any_q || cur_sres) init_rewalk_q <= 1'b1;
                else begin
                  k_q <= k_q + CW'(GROUP_SIZE);
                  grp_first_q <= sbase_ext + ID_BITS'(k_q + CW'(GROUP_SIZE));
                end
              end else j_q <= j_q + 1'b1;
            end else begin
              if (last_j) begin
                j_q <= '0; init_rewalk_q <= 1'b0; grp_any_q <= 1'b0;
                k_q <= k_q + CW'(GROUP_SIZE);
                grp_first_q <= sbase_ext + ID_BITS'(k_q + CW'(GROUP_SIZE));
              end else j_q <= j_q + 1'b1;
            end
          end
          if (state_d == S_INIT_MON) begin
            k_q <= '0; j_q <= '0;
          end
        end
        S_INIT_MON: k_q <= k_q + 1'b1;
        S_GRP_RD: begin
          g_head_q <= g_head_inc;
          g_fill_q <= g_fill_q - 1'b1;
        end
        S_GRP_WAIT: begin gval_q <= g_rd; j_q <= '0; end
        S_SPLIT: j_q <= last_j ? '0 : j_q + 1'b1;
        S_SGL_RD: begin
          s_head_q <= s_head_inc;
          s_fill_q <= s_fill_q - 1'b1;
        end
        S_SGL_WAIT: begin
          id_q <= 12'(s_rd);
          if (cmd_q == CMD_DUMMY) begin
            dummy_valid_q <= 1'b1; dummy_id_q <= s_rd;
          end
        end
        S_MON_RD: begin
          m_head_q <= m_head_inc;
          m_fill_q <= m_fill_q - 1'b1;
        end
        S_MON_WAIT: id_q <= 12'(m_rd);
        S_GRPA_RD: begin
          g_head_q <= g_head_inc;
          g_fill_q <= g_fill_q - 1'b1;
        end
        S_GRPA_WAIT: id_q <= 12'(g_rd);
        default: ;
      endcase
    end
  end

  // status outputs
  logic [CW-1:0] res_n;
  logic [CW:0] have, target;
  always_comb begin
    res_n = (cfg.sync_rhi > cfg.sync_rlo) ? CW'(cfg.sync_rhi - cfg.sync_rlo) : '0;
    have = (CW+1)'(s_fill_q) + (CW+1)'(g_fill_q) * (CW+1)'(GROUP_SIZE);
    target = (CW+1)'(eff_sync) - (CW+1)'(res_n);
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = state_q == S_DONE;
  assign id_out_o = id_q;
  assign status_o = st_q;
  assign all_sync_free_o = (res_n <= eff_sync) && (have == target);

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(s_fill_q) <= SYNC_CAPACITY && 32'(m_fill_q) <= MON_CAPACITY)
    else $error("fill overrun");
  a_none_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> id_out_o == '0) else $error("id on failure");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> state_q == S_DISPATCH) else $error("request lost");
`endif
endmodule
